>>> hdl/bkf_pkg.sv
// ----------------------------------------------------------------------------
// bkf_pkg: shared types, constants and helpers for the bearing Kalman filter
// Register map, sequencer op table, memory reset values and saturation.
// ----------------------------------------------------------------------------
package bkf_pkg;

    localparam int unsigned CFG_W = 23;

    // register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_TIME_STEP    = 3'd0;
    localparam logic [2:0] REG_CAMERA_NOISE = 3'd1;
    localparam logic [2:0] REG_LASER_NOISE  = 3'd2;
    localparam logic [2:0] REG_SINGLE_NOISE = 3'd3;
    localparam logic [2:0] REG_Q_POSITION   = 3'd4;
    localparam logic [2:0] REG_Q_RATE       = 3'd5;
    localparam logic [2:0] REG_Q_CROSS      = 3'd6;

    localparam logic [CFG_W-1:0] RST_TIME_STEP    = 23'd655360;
    localparam logic [CFG_W-1:0] RST_CAMERA_NOISE = 23'd13107;
    localparam logic [CFG_W-1:0] RST_LASER_NOISE  = 23'd327680;
    localparam logic [CFG_W-1:0] RST_SINGLE_NOISE = 23'd39322;
    localparam logic [CFG_W-1:0] RST_Q_POSITION   = 23'd655360;
    localparam logic [CFG_W-1:0] RST_Q_RATE       = 23'd655;
    localparam logic [CFG_W-1:0] RST_Q_CROSS      = 23'd655;

    // op sequence: 0..25 predict, 26..45 correction
    localparam logic [5:0] STEP_PRED_LAST = 6'd25;
    localparam logic [5:0] STEP_UPD_FIRST = 6'd26;
    localparam logic [5:0] STEP_LAST      = 6'd45;

    localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_MIN = 32'h8000_0000;

    typedef enum logic [1:0] {B_COV, B_ST, B_ONE, B_Y} t_bsel;
    typedef enum logic [2:0] {A_DT, A_QP, A_QR, A_QC, A_GAIN} t_asel;

    // one read-modify-write: dst = sat(dst +/- rnd(a * b))
    typedef struct packed {
        t_bsel      b_sel;
        logic [3:0] src;
        logic       dst_st;
        logic [3:0] dst;
        t_asel      a_sel;
        logic [1:0] gidx;
        logic       sub;
    } t_op;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE,
        S_OP_SRC, S_OP_DST, S_OP_MUL, S_OP_WR,
        S_JZ_A, S_JZ_B, S_JZ_C, S_JR_A, S_JR_B,
        S_DIV_INIT, S_DIV_RUN, S_DIV_END,
        S_UPD_RD, S_UPD_CHK, S_G_RD, S_G_DIV,
        S_OUT_WAIT, S_OUT_RD
    } t_state;

    typedef enum logic [1:0] {PH_JZ, PH_JR, PH_GAIN} t_phase;

    function automatic t_op op_decode(input logic [5:0] step);
        t_op        op;
        logic [5:0] k;
        op = '{b_sel: B_COV, src: 4'd0, dst_st: 1'b0, dst: 4'd0,
               a_sel: A_DT, gidx: 2'd0, sub: 1'b0};
        k  = 6'd0;
        case (step) inside
            6'd0: begin
                op.b_sel = B_ST; op.src = 4'd2; op.dst_st = 1'b1; op.dst = 4'd0;
            end
            6'd1: begin
                op.b_sel = B_ST; op.src = 4'd3; op.dst_st = 1'b1; op.dst = 4'd1;
            end
            [6'd2:6'd9]: begin
                // rows 0/1 += dt * rows 2/3
                k      = step - 6'd2;
                op.dst = {1'b0, k[2], k[1:0]};
                op.src = {1'b1, k[2], k[1:0]};
            end
            [6'd10:6'd17]: begin
                // cols 0/1 += dt * cols 2/3
                k      = step - 6'd10;
                op.dst = {k[2:1], 1'b0, k[0]};
                op.src = {k[2:1], 1'b1, k[0]};
            end
            [6'd18:6'd25]: begin
                k        = step - 6'd18;
                op.b_sel = B_ONE;
                case (k[2:0])
                    3'd0: begin op.dst = 4'd0;  op.a_sel = A_QP; end
                    3'd1: begin op.dst = 4'd5;  op.a_sel = A_QP; end
                    3'd2: begin op.dst = 4'd10; op.a_sel = A_QR; end
                    3'd3: begin op.dst = 4'd15; op.a_sel = A_QR; end
                    3'd4: begin op.dst = 4'd2;  op.a_sel = A_QC; end
                    3'd5: begin op.dst = 4'd8;  op.a_sel = A_QC; end
                    3'd6: begin op.dst = 4'd7;  op.a_sel = A_QC; end
                    default: begin op.dst = 4'd13; op.a_sel = A_QC; end
                endcase
            end
            [6'd26:6'd29]: begin
                k         = step - 6'd26;
                op.b_sel  = B_Y;
                op.dst_st = 1'b1;
                op.dst    = {2'b00, k[1:0]};
                op.a_sel  = A_GAIN;
                op.gidx   = k[1:0];
            end
            [6'd30:6'd45]: begin
                // rows 3..0, row 0 last so its old values feed every row
                k        = step - 6'd30;
                op.gidx  = ~k[3:2];
                op.dst   = {~k[3:2], k[1:0]};
                op.src   = {2'b00, k[1:0]};
                op.a_sel = A_GAIN;
                op.sub   = 1'b1;
            end
            default: ;
        endcase
        return op;
    endfunction

    function automatic logic [31:0] cov_reset(input logic [3:0] idx);
        logic [31:0] v;
        case (idx) inside
            4'd0, 4'd5, 4'd10, 4'd15: v = 32'd65536;
            4'd2, 4'd7, 4'd8, 4'd13:  v = 32'd655;
            default:                  v = 32'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
        logic signed [31:0] r;
        if (v > 51'sd2147483647)
            r = SAT_MAX;
        else if (v < -51'sd2147483648)
            r = SAT_MIN;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

>>> hdl/bearing_kalman_fusion_unit.sv
// ----------------------------------------------------------------------------
// bearing_kalman_fusion_unit: four-state bearing/range Kalman filter
// Predict plus camera/laser bearing correction, signed Q16.16, APB config.
// ----------------------------------------------------------------------------
// One input beat is one time step. The block predicts (x, P) with time_step
// and the Q registers, then corrects with the valid bearings: a joint update
// when both are valid, a scalar update with single_noise when one is, none
// otherwise; it then emits the new state and the update kind as one beat.
// State and covariance live in two small synchronous RAMs and are worked on
// by one read-modify-write op at a time through a single 33x33 multiplier
// (source read, destination read, multiply, write), with divisions done by
// a 32-step restoring divider. The next beat is taken once the result has
// been queued in the output register. After reset an init pass loads the
// covariance and state RAMs; no input beat is taken during it.
// ----------------------------------------------------------------------------
module bearing_kalman_fusion_unit
    import bkf_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input stream
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [39:0]  i_s_tdata,   // [18:0] camera_angle, [37:19] laser_angle
    input  logic [1:0]   i_s_tuser,   // [0] camera_valid, [1] laser_valid
    // result stream
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [127:0] o_m_tdata,   // bearing_est, range_est, bearing_rate_est,
                                      // range_rate_est, 32 bits each from bit 0
    output logic [1:0]   o_m_tuser,   // [1:0] update_kind
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    // ---------------- configuration registers ----------------
    logic [CFG_W-1:0] r_time_step, r_camera_noise, r_laser_noise, r_single_noise;
    logic [CFG_W-1:0] r_q_position, r_q_rate, r_q_cross;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step    <= RST_TIME_STEP;
            r_camera_noise <= RST_CAMERA_NOISE;
            r_laser_noise  <= RST_LASER_NOISE;
            r_single_noise <= RST_SINGLE_NOISE;
            r_q_position   <= RST_Q_POSITION;
            r_q_rate       <= RST_Q_RATE;
            r_q_cross      <= RST_Q_CROSS;
        end else if (psel && penable && pwrite) begin
            case (paddr[4:2])
                REG_TIME_STEP:    r_time_step    <= pwdata[CFG_W-1:0];
                REG_CAMERA_NOISE: r_camera_noise <= pwdata[CFG_W-1:0];
                REG_LASER_NOISE:  r_laser_noise  <= pwdata[CFG_W-1:0];
                REG_SINGLE_NOISE: r_single_noise <= pwdata[CFG_W-1:0];
                REG_Q_POSITION:   r_q_position   <= pwdata[CFG_W-1:0];
                REG_Q_RATE:       r_q_rate       <= pwdata[CFG_W-1:0];
                REG_Q_CROSS:      r_q_cross      <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_TIME_STEP:    prdata = {9'd0, r_time_step};
            REG_CAMERA_NOISE: prdata = {9'd0, r_camera_noise};
            REG_LASER_NOISE:  prdata = {9'd0, r_laser_noise};
            REG_SINGLE_NOISE: prdata = {9'd0, r_single_noise};
            REG_Q_POSITION:   prdata = {9'd0, r_q_position};
            REG_Q_RATE:       prdata = {9'd0, r_q_rate};
            REG_Q_CROSS:      prdata = {9'd0, r_q_cross};
            default:          prdata = 32'd0;
        endcase
    end

    // ---------------- state ----------------
    t_state r_state, n_state;
    t_phase r_phase;

    logic [5:0] r_step;     // op index; also the RAM init counter
    logic [1:0] r_gi;       // gain index
    logic [4:0] r_dcnt;     // divider step
    logic [2:0] r_oi;       // output readout index

    logic                     r_cam, r_las;
    logic signed [18:0]       r_zc, r_zl;
    logic signed [18:0]       r_z;      // effective measurement
    logic [CFG_W-1:0]         r_r;      // effective measurement variance
    logic signed [31:0]       r_y;      // innovation
    logic [31:0]              r_s;      // innovation variance, positive
    logic signed [31:0]       r_gain [4];

    logic signed [32:0]       r_b;
    logic signed [31:0]       r_dval;
    logic signed [65:0]       r_prod;
    logic signed [49:0]       r_acc;

    // divider
    logic signed [49:0]       r_dnum;
    logic [33:0]              r_dden;
    logic [33:0]              r_drem;
    logic [31:0]              r_dq;
    logic                     r_dneg, r_dovf;

    // RAMs
    logic [31:0]              cov_mem [16];
    logic [31:0]              st_mem  [4];
    logic signed [31:0]       r_cov_rd, r_st_rd;
    logic [3:0]               cov_raddr, cov_waddr;
    logic [1:0]               st_raddr, st_waddr;
    logic                     cov_we, st_we;
    logic [31:0]              cov_wdata, st_wdata;

    // output register
    logic                     r_m_valid;
    logic [127:0]             r_out;
    logic [1:0]               r_out_kind;

    always_ff @(posedge i_clk) begin
        if (cov_we)
            cov_mem[cov_waddr] <= cov_wdata;
        r_cov_rd <= cov_mem[cov_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (st_we)
            st_mem[st_waddr] <= st_wdata;
        r_st_rd <= st_mem[st_raddr];
    end

    // ---------------- datapath combinational ----------------
    t_op                op;
    logic signed [32:0] a_val, b_val, mul_a, mul_b;
    logic signed [65:0] mul_p, rnd_full;
    logic signed [49:0] rnd_val;
    logic signed [50:0] acc_sum;
    logic signed [31:0] wr_val;
    logic [23:0]        jsum;
    logic signed [49:0] jsum_s;
    logic signed [19:0] zpair;
    logic signed [33:0] s_full;
    logic [49:0]        d_mag;
    logic               d_ovf;
    logic [34:0]        d_t, d_sub;
    logic               d_ge;
    logic [32:0]        d_qn;
    logic signed [31:0] div_res;
    logic [1:0]         oi_m1;

    assign op = op_decode(r_step);

    always_comb begin
        case (op.a_sel)
            A_DT:    a_val = $signed({10'd0, r_time_step});
            A_QP:    a_val = $signed({10'd0, r_q_position});
            A_QR:    a_val = $signed({10'd0, r_q_rate});
            A_QC:    a_val = $signed({10'd0, r_q_cross});
            default: a_val = 33'(r_gain[op.gidx]);
        endcase
        case (op.b_sel)
            B_COV:   b_val = 33'(r_cov_rd);
            B_ST:    b_val = 33'(r_st_rd);
            B_ONE:   b_val = 33'sd65536;   // rnd(q * 1.0) == q
            default: b_val = 33'(r_y);
        endcase
    end

    always_comb begin
        case (r_state)
            S_JZ_A: begin
                mul_a = $signed({10'd0, r_laser_noise});
                mul_b = 33'(r_zc);
            end
            S_JZ_B: begin
                mul_a = $signed({10'd0, r_camera_noise});
                mul_b = 33'(r_zl);
            end
            S_JR_A: begin
                mul_a = $signed({10'd0, r_camera_noise});
                mul_b = $signed({10'd0, r_laser_noise});
            end
            default: begin
                mul_a = a_val;
                mul_b = r_b;
            end
        endcase
    end

    assign mul_p    = mul_a * mul_b;
    assign rnd_full = r_prod + 66'sd32768;
    assign rnd_val  = rnd_full[65:16];
    assign acc_sum  = op.sub ? (51'(r_dval) - 51'(rnd_val)) : (51'(r_dval) + 51'(rnd_val));
    assign wr_val   = sat32(acc_sum);

    assign jsum   = {1'b0, r_camera_noise} + {1'b0, r_laser_noise};
    assign jsum_s = $signed({26'd0, jsum});
    assign zpair  = 20'(r_zc) + 20'(r_zl);
    assign s_full = 34'(r_cov_rd) + $signed({11'd0, r_r});

    // divider: floor(num / den), saturated to 32 bits
    assign d_mag = r_dnum[49] ? 50'(-r_dnum) : 50'(r_dnum);
    assign d_ovf = {16'd0, d_mag[49:32]} >= r_dden;
    assign d_t   = {r_drem, r_dq[31]};
    assign d_ge  = d_t >= {1'b0, r_dden};
    assign d_sub = d_t - {1'b0, r_dden};
    assign d_qn  = {1'b0, r_dq} + {32'd0, (r_drem != 34'd0)};

    always_comb begin
        if (r_dovf)
            div_res = r_dneg ? SAT_MIN : SAT_MAX;
        else if (!r_dneg)
            div_res = r_dq[31] ? SAT_MAX : r_dq;
        else if (d_qn > 33'h0_8000_0000)
            div_res = SAT_MIN;
        else
            div_res = 32'(-d_qn);
    end

    assign oi_m1 = r_oi[1:0] - 2'd1;

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT:     if (r_step[3:0] == 4'd15) n_state = S_IDLE;
            S_IDLE:     if (i_s_tvalid) n_state = S_OP_SRC;
            S_OP_SRC:   n_state = S_OP_DST;
            S_OP_DST:   n_state = S_OP_MUL;
            S_OP_MUL:   n_state = S_OP_WR;
            S_OP_WR: begin
                if (r_step == STEP_PRED_LAST) begin
                    if (r_cam && r_las)
                        n_state = (jsum == 24'd0) ? S_UPD_RD : S_JZ_A;
                    else if (r_cam || r_las)
                        n_state = S_UPD_RD;
                    else
                        n_state = S_OUT_WAIT;
                end else if (r_step == STEP_LAST) begin
                    n_state = S_OUT_WAIT;
                end else begin
                    n_state = S_OP_SRC;
                end
            end
            S_JZ_A:     n_state = S_JZ_B;
            S_JZ_B:     n_state = S_JZ_C;
            S_JZ_C:     n_state = S_DIV_INIT;
            S_JR_A:     n_state = S_JR_B;
            S_JR_B:     n_state = S_DIV_INIT;
            S_DIV_INIT: n_state = S_DIV_RUN;
            S_DIV_RUN:  if (r_dcnt == 5'd31) n_state = S_DIV_END;
            S_DIV_END: begin
                case (r_phase)
                    PH_JZ:   n_state = S_JR_A;
                    PH_JR:   n_state = S_UPD_RD;
                    default: n_state = (r_gi == 2'd3) ? S_OP_SRC : S_G_RD;
                endcase
            end
            S_UPD_RD:   n_state = S_UPD_CHK;
            S_UPD_CHK:  n_state = (s_full <= 34'sd0) ? S_OUT_WAIT : S_G_RD;
            S_G_RD:     n_state = S_G_DIV;
            S_G_DIV:    n_state = S_DIV_INIT;
            S_OUT_WAIT: if (!r_m_valid) n_state = S_OUT_RD;
            S_OUT_RD:   if (r_oi == 3'd4) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // ---------------- RAM port control ----------------
    always_comb begin
        cov_raddr = 4'd0;
        st_raddr  = 2'd0;
        cov_we    = 1'b0;
        st_we     = 1'b0;
        cov_waddr = op.dst;
        st_waddr  = op.dst[1:0];
        cov_wdata = wr_val;
        st_wdata  = wr_val;
        case (r_state)
            S_INIT: begin
                cov_we    = 1'b1;
                st_we     = 1'b1;
                cov_waddr = r_step[3:0];
                st_waddr  = r_step[1:0];
                cov_wdata = cov_reset(r_step[3:0]);
                st_wdata  = 32'd0;
            end
            S_OP_SRC: begin
                cov_raddr = op.src;
                st_raddr  = op.src[1:0];
            end
            S_OP_DST: begin
                cov_raddr = op.dst;
                st_raddr  = op.dst[1:0];
            end
            S_OP_WR: begin
                cov_we = !op.dst_st;
                st_we  = op.dst_st;
            end
            S_G_RD:   cov_raddr = {r_gi, 2'b00};
            S_OUT_RD: st_raddr  = r_oi[1:0];
            default: ;
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_step    <= 6'd0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_m_valid && i_m_tready)
                r_m_valid <= 1'b0;
            case (r_state)
                S_INIT:    r_step <= (r_step[3:0] == 4'd15) ? 6'd0 : r_step + 6'd1;
                S_IDLE:    r_step <= 6'd0;
                S_OP_WR:   if (r_step != STEP_PRED_LAST && r_step != STEP_LAST)
                               r_step <= r_step + 6'd1;
                S_DIV_END: if (r_phase == PH_GAIN && r_gi == 2'd3)
                               r_step <= STEP_UPD_FIRST;
                S_OUT_RD:  if (r_oi == 3'd4) r_m_valid <= 1'b1;
                default: ;
            endcase
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    r_cam <= i_s_tuser[0];
                    r_las <= i_s_tuser[1];
                    r_zc  <= i_s_tdata[18:0];
                    r_zl  <= i_s_tdata[37:19];
                end
            end
            S_OP_DST: r_b <= b_val;
            S_OP_MUL: begin
                r_prod <= mul_p;
                r_dval <= op.dst_st ? r_st_rd : r_cov_rd;
            end
            S_OP_WR: begin
                if (r_step == STEP_PRED_LAST) begin
                    if (r_cam && r_las) begin
                        // zero noise sum: floor of the mean, no variance
                        r_z <= zpair[19:1];
                        r_r <= '0;
                    end else begin
                        r_z <= r_cam ? r_zc : r_zl;
                        r_r <= r_single_noise;
                    end
                end
            end
            S_JZ_A: r_prod <= mul_p;
            S_JZ_B: begin
                r_prod <= mul_p;
                r_acc  <= r_prod[49:0];
            end
            S_JZ_C: begin
                r_dnum  <= ((r_acc + r_prod[49:0]) <<< 1) + jsum_s;
                r_dden  <= {9'd0, jsum, 1'b0};
                r_phase <= PH_JZ;
            end
            S_JR_A: r_prod <= mul_p;
            S_JR_B: begin
                r_dnum  <= (r_prod[49:0] <<< 1) + jsum_s;
                r_dden  <= {9'd0, jsum, 1'b0};
                r_phase <= PH_JR;
            end
            S_DIV_INIT: begin
                r_dneg <= r_dnum[49];
                r_dovf <= d_ovf;
                r_drem <= {16'd0, d_mag[49:32]};
                r_dq   <= d_mag[31:0];
                r_dcnt <= 5'd0;
            end
            S_DIV_RUN: begin
                r_drem <= d_ge ? d_sub[33:0] : d_t[33:0];
                r_dq   <= {r_dq[30:0], d_ge};
                r_dcnt <= r_dcnt + 5'd1;
            end
            S_DIV_END: begin
                case (r_phase)
                    PH_JZ: r_z <= div_res[18:0];
                    PH_JR: r_r <= div_res[CFG_W-1:0];
                    default: begin
                        r_gain[r_gi] <= div_res;
                        r_gi         <= r_gi + 2'd1;
                    end
                endcase
            end
            S_UPD_CHK: begin
                r_s  <= s_full[31:0];
                r_y  <= sat32(51'(r_z) - 51'(r_st_rd));
                r_gi <= 2'd0;
            end
            S_G_DIV: begin
                // gain = round(P_i0 * 1.0 / s)
                r_dnum  <= (50'(r_cov_rd) <<< 17) + $signed({18'd0, r_s});
                r_dden  <= {1'b0, r_s, 1'b0};
                r_phase <= PH_GAIN;
            end
            S_OUT_WAIT: r_oi <= 3'd0;
            S_OUT_RD: begin
                r_oi <= r_oi + 3'd1;
                if (r_oi != 3'd0)
                    r_out[32*oi_m1 +: 32] <= r_st_rd;
                if (r_oi == 3'd4)
                    r_out_kind <= {r_las, r_cam};
            end
            default: ;
        endcase
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_out;
    assign o_m_tuser  = r_out_kind;

endmodule

>>> test/bearing_kalman_fusion_unit_tb.sv
// ----------------------------------------------------------------------------
// bearing_kalman_fusion_unit_tb: self-checking bench for the bearing filter
// Drives bearing beats with bursty timing and random output stalls, predicts
// every result beat with a fixed-point filter model and checks each field.
// ----------------------------------------------------------------------------
module bearing_kalman_fusion_unit_tb;
    import bkf_pkg::*;

    localparam int NUM_REGS   = 7;
    localparam int RAND_BEATS = 625;
    localparam int IDLE_LIMIT = 20000;   // watchdog bound; covers the slowest beat plus stalls
    localparam int DRAIN_CYC  = 500;
    localparam int ANG_MAX    = 205887;

    // expected output beat
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] rr;
        logic [31:0] br;
        logic [31:0] rg;
        logic [31:0] bg;
    } t_est;

    // ------------------------------------------------------------------------
    // Filter predictor plus queue of expected estimate beats
    // ------------------------------------------------------------------------
    class fusion_scoreboard;
        logic [CFG_W-1:0] regs [NUM_REGS];
        longint           xs [4];
        longint           pc [16];
        t_est             pending [$];
        int               n_err;
        int               n_ok;
        int               kind_seen [4];

        function new();
            n_err = 0;
            n_ok  = 0;
            foreach (kind_seen[i]) kind_seen[i] = 0;
            regs[REG_TIME_STEP]    = RST_TIME_STEP;
            regs[REG_CAMERA_NOISE] = RST_CAMERA_NOISE;
            regs[REG_LASER_NOISE]  = RST_LASER_NOISE;
            regs[REG_SINGLE_NOISE] = RST_SINGLE_NOISE;
            regs[REG_Q_POSITION]   = RST_Q_POSITION;
            regs[REG_Q_RATE]       = RST_Q_RATE;
            regs[REG_Q_CROSS]      = RST_Q_CROSS;
            foreach (xs[i]) xs[i] = 0;
            foreach (pc[i]) pc[i] = 0;
            pc[0] = 65536; pc[5] = 65536; pc[10] = 65536; pc[15] = 65536;
            pc[2] = 655;   pc[8] = 655;   pc[7] = 655;    pc[13] = 655;
        endfunction

        function void set_reg(logic [2:0] idx, logic [CFG_W-1:0] val);
            regs[idx] = val;
        endfunction

        // floor division, any signs
        function longint fdiv(longint n, longint d);
            longint q;
            q = n / d;
            if ((n % d) != 0 && ((n < 0) != (d < 0))) q -= 1;
            return q;
        endfunction

        function longint rnd16(longint v);
            return fdiv(v + 32768, 65536);
        endfunction

        function longint sat(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function void time_update();
            longint dt;
            longint a [16];
            dt = longint'(regs[REG_TIME_STEP]);
            xs[0] = sat(xs[0] + rnd16(dt * xs[2]));
            xs[1] = sat(xs[1] + rnd16(dt * xs[3]));
            a = pc;
            for (int j = 0; j < 4; j++) begin
                a[j]     = sat(pc[j] + rnd16(dt * pc[8 + j]));
                a[4 + j] = sat(pc[4 + j] + rnd16(dt * pc[12 + j]));
            end
            for (int i = 0; i < 4; i++) begin
                pc[i*4]     = sat(a[i*4] + rnd16(dt * a[i*4 + 2]));
                pc[i*4 + 1] = sat(a[i*4 + 1] + rnd16(dt * a[i*4 + 3]));
                pc[i*4 + 2] = a[i*4 + 2];
                pc[i*4 + 3] = a[i*4 + 3];
            end
            pc[0]  = sat(pc[0] + regs[REG_Q_POSITION]);
            pc[5]  = sat(pc[5] + regs[REG_Q_POSITION]);
            pc[10] = sat(pc[10] + regs[REG_Q_RATE]);
            pc[15] = sat(pc[15] + regs[REG_Q_RATE]);
            pc[2]  = sat(pc[2] + regs[REG_Q_CROSS]);
            pc[8]  = sat(pc[8] + regs[REG_Q_CROSS]);
            pc[7]  = sat(pc[7] + regs[REG_Q_CROSS]);
            pc[13] = sat(pc[13] + regs[REG_Q_CROSS]);
        endfunction

        function void bearing_correct(longint z, longint r);
            longint s, y;
            longint g [4];
            longint row0 [4];
            s = pc[0] + r;
            if (s <= 0) return;   // non-positive innovation variance: no correction
            y = sat(z - xs[0]);
            for (int i = 0; i < 4; i++) begin
                g[i]    = sat(fdiv(2 * (pc[i*4] * 65536) + s, 2 * s));
                row0[i] = pc[i];
            end
            for (int i = 0; i < 4; i++) begin
                xs[i] = sat(xs[i] + rnd16(g[i] * y));
                for (int j = 0; j < 4; j++)
                    pc[i*4 + j] = sat(pc[i*4 + j] - rnd16(g[i] * row0[j]));
            end
        endfunction

        // one accepted input beat
        function void note_input(logic cv, logic signed [18:0] ca,
                                 logic lv, logic signed [18:0] la);
            longint zc, zl, rc, rl, sum;
            t_est   e;
            zc = ca;
            zl = la;
            time_update();
            if (cv && lv) begin
                rc  = regs[REG_CAMERA_NOISE];
                rl  = regs[REG_LASER_NOISE];
                sum = rc + rl;
                if (sum == 0)
                    bearing_correct(fdiv(zc + zl, 2), 0);
                else
                    bearing_correct(fdiv(2 * (rl * zc + rc * zl) + sum, 2 * sum),
                                    fdiv(2 * (rc * rl) + sum, 2 * sum));
            end else if (cv) begin
                bearing_correct(zc, regs[REG_SINGLE_NOISE]);
            end else if (lv) begin
                bearing_correct(zl, regs[REG_SINGLE_NOISE]);
            end
            e.bg   = xs[0][31:0];
            e.rg   = xs[1][31:0];
            e.br   = xs[2][31:0];
            e.rr   = xs[3][31:0];
            e.kind = {lv, cv};
            pending = {pending, e};
        endfunction

        function void check_result(logic [127:0] data, logic [1:0] kind);
            t_est e;
            t_est got;
            got = {kind, data[127:96], data[95:64], data[63:32], data[31:0]};
            if (pending.size() == 0) begin
                n_err++;
                if (n_err <= 10)
                    $display("ERROR: unexpected output beat kind=%0d bearing=%h",
                             kind, data[31:0]);
                return;
            end
            e = pending.pop_front();
            if (got !== e) begin
                n_err++;
                if (n_err <= 10) begin
                    $display("ERROR: beat %0d", n_ok + n_err);
                    $display("  exp bg=%h rg=%h br=%h rr=%h kind=%0d",
                             e.bg, e.rg, e.br, e.rr, e.kind);
                    $display("  got bg=%h rg=%h br=%h rr=%h kind=%0d",
                             got.bg, got.rg, got.br, got.rr, got.kind);
                end
            end else begin
                n_ok++;
                kind_seen[kind]++;
            end
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [39:0]  i_s_tdata;
    logic [1:0]   i_s_tuser;
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [127:0] o_m_tdata;
    logic [1:0]   o_m_tuser;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [4:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    bearing_kalman_fusion_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    fusion_scoreboard sb;
    int  idle_cycles = 0;
    int  beats_sent;
    bit  hold_sink;      // forces a long receiver hold-off
    bit  sink_quiet;     // receiver stays ready (no-stall stretch)

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // watchdog: cycles with no beat accepted on either side
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("Timeout: no beat moved for %0d cycles", IDLE_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    // input beats go to the predictor, output beats to the checker, at the accepting edge
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready)
            sb.note_input(i_s_tuser[0], i_s_tdata[18:0], i_s_tuser[1], i_s_tdata[37:19]);
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_result(o_m_tdata, o_m_tuser);
    end

    // receiver: own stall pattern, a quiet mode and a long forced hold-off
    initial begin
        int r;
        i_m_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            r = $urandom_range(0, 99);
            if (hold_sink)       i_m_tready <= 1'b0;
            else if (sink_quiet) i_m_tready <= 1'b1;
            else                 i_m_tready <= (r < 60);
        end
    end

    // one APB write: setup then access; register loads in the access cycle
    task automatic apb_write(logic [2:0] idx, logic [CFG_W-1:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {9'd0, val};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        sb.set_reg(idx, val);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // wait until every expected beat is back, then let the datapath settle
    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    // offer one beat and hold it until accepted
    task automatic send_beat(int cv, int ca, int lv, int la);
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= {1'(lv), 1'(cv)};
        i_s_tdata  <= {2'b00, 19'(la), 19'(ca)};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        beats_sent++;
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
    endtask

    function automatic int rand_angle();
        int m;
        m = $urandom_range(0, 9);
        if (m == 0) return ANG_MAX;
        if (m == 1) return -ANG_MAX;
        if (m == 2) return $signed(19'($urandom));   // full 19-bit field
        return int'($urandom_range(0, 2 * ANG_MAX)) - ANG_MAX;
    endfunction

    // bursty random beats; valid drops after each burst, mostly for a random gap
    task automatic random_burst(int n);
        int left;
        left = n;
        while (left > 0) begin
            int burst;
            burst = $urandom_range(1, 8);
            for (int k = 0; k < burst && left > 0; k++, left--)
                send_beat($urandom_range(0, 1), rand_angle(), $urandom_range(0, 1),
                          rand_angle());
            stop_sending();
            if ($urandom_range(0, 3) != 0)
                repeat ($urandom_range(1, 400)) @(negedge i_clk);
        end
    endtask

    // random register set, extremes now and then
    function automatic logic [CFG_W-1:0] pick_val(int lo);
        int m;
        m = $urandom_range(0, 5);
        if (m == 0) return CFG_W'(lo);
        if (m == 1) return 23'd6553600;
        if (m == 2) return 23'h7FFFFF;
        return CFG_W'($urandom_range(lo, 6553600 / 16));
    endfunction

    initial begin
        sb          = new();
        beats_sent  = 0;
        hold_sink   = 1'b0;
        sink_quiet  = 1'b0;
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: every update kind and the bearing extremes at reset config
        send_beat(0, 0, 0, 0);
        send_beat(1, ANG_MAX, 0, 0);
        send_beat(0, 0, 1, -ANG_MAX);
        send_beat(1, -ANG_MAX, 1, ANG_MAX);
        send_beat(1, ANG_MAX, 1, ANG_MAX);
        send_beat(1, -262144, 1, 262143);   // raw field extremes
        send_beat(0, 12345, 0, -12345);     // angles ignored, predict only
        stop_sending();
        drain();

        // zero noise sum in the joint update, zero Q, smallest step
        apb_write(REG_CAMERA_NOISE, 23'd0);
        apb_write(REG_LASER_NOISE, 23'd0);
        apb_write(REG_SINGLE_NOISE, 23'd0);
        apb_write(REG_Q_POSITION, 23'd0);
        apb_write(REG_Q_RATE, 23'd0);
        apb_write(REG_Q_CROSS, 23'd0);
        apb_write(REG_TIME_STEP, 23'd1);
        send_beat(1, 3, 1, -4);             // odd sum: floor of the mean
        send_beat(1, ANG_MAX, 1, -ANG_MAX);
        send_beat(1, -5, 0, 0);
        send_beat(0, 0, 1, 7);
        send_beat(0, 0, 0, 0);
        stop_sending();
        drain();

        // largest values: pushes covariance into saturation
        apb_write(REG_TIME_STEP, 23'h7FFFFF);
        apb_write(REG_Q_POSITION, 23'h7FFFFF);
        apb_write(REG_Q_RATE, 23'h7FFFFF);
        apb_write(REG_Q_CROSS, 23'h7FFFFF);
        apb_write(REG_CAMERA_NOISE, 23'd6553600);
        apb_write(REG_LASER_NOISE, 23'd1);
        apb_write(REG_SINGLE_NOISE, 23'h7FFFFF);
        for (int k = 0; k < 8; k++)
            send_beat(int'(k[0]), ANG_MAX, int'(k[1]), -ANG_MAX);
        stop_sending();
        drain();

        // random phases; fresh settings between them
        for (int ph = 0; ph < 8; ph++) begin
            apb_write(REG_TIME_STEP, pick_val(1));
            apb_write(REG_CAMERA_NOISE, pick_val(1));
            apb_write(REG_LASER_NOISE, pick_val(1));
            apb_write(REG_SINGLE_NOISE, pick_val(1));
            apb_write(REG_Q_POSITION, pick_val(0));
            apb_write(REG_Q_RATE, pick_val(0));
            apb_write(REG_Q_CROSS, pick_val(0));
            sink_quiet = (ph == 2);
            if (ph == 4) begin
                // long receiver hold-off while the sender keeps offering
                fork
                    begin
                        hold_sink = 1'b1;
                        repeat (3000) @(posedge i_clk);
                        hold_sink = 1'b0;
                    end
                    random_burst(RAND_BEATS / 8);
                join
            end else begin
                random_burst(RAND_BEATS / 8);
            end
            stop_sending();
            drain();
        end

        // defaults restored for a final stretch
        apb_write(REG_TIME_STEP, RST_TIME_STEP);
        apb_write(REG_CAMERA_NOISE, RST_CAMERA_NOISE);
        apb_write(REG_LASER_NOISE, RST_LASER_NOISE);
        apb_write(REG_SINGLE_NOISE, RST_SINGLE_NOISE);
        apb_write(REG_Q_POSITION, RST_Q_POSITION);
        apb_write(REG_Q_RATE, RST_Q_RATE);
        apb_write(REG_Q_CROSS, RST_Q_CROSS);
        random_burst(25);
        stop_sending();
        drain();

        $display("Covered %0d input beats over 12 register settings, %0d checked.",
                 beats_sent, sb.n_ok);
        $display("Update kinds seen: predict %0d, camera %0d, laser %0d, joint %0d.",
                 sb.kind_seen[0], sb.kind_seen[1], sb.kind_seen[2], sb.kind_seen[3]);
        if (sb.n_err == 0 && sb.pending.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("%0d errors, %0d beats missing", sb.n_err, sb.pending.size());
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
